FILE: hdl/wsnt_pkg.sv
// Shared types and constants for the weekly schedule next-time block.
// Used by every module of the block; no dependencies.
package wsnt_pkg;

    // Field widths
    localparam int EPOCH_BITS    = 40;
    localparam int OUT_BITS      = EPOCH_BITS + 1;
    localparam int SEC_BITS      = 17;
    localparam int WDAY_BITS     = 3;
    localparam int MASK_BITS     = 7;
    localparam int RCNT_BITS     = 8;
    localparam int RMIN_BITS     = 11;
    localparam int STEP_BITS     = 17;                    // 60 * 2047 < 2^17
    localparam int LIMIT_BITS    = RCNT_BITS + STEP_BITS;
    localparam int QUO_BITS      = RCNT_BITS;             // quotient needed only below count
    localparam int PROD_BITS     = QUO_BITS + 1 + STEP_BITS;
    localparam int DOFS_BITS     = 20;                    // 7 * 86400 < 2^20
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_IDX_BITS  = 3;

    // Time constants
    localparam int DAY_SECS  = 86400;
    localparam int MIN_SECS  = 60;
    localparam int WEEK_DAYS = 7;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DAY_MASK   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRE_SECS  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_CNT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_MIN = 3'd4;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] now_epoch;
        logic [WDAY_BITS-1:0]  weekday;
        logic [SEC_BITS-1:0]   day_seconds;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] next_epoch;
        logic                never;
    } t_out_item;

    typedef struct packed {
        logic                 enabled;
        logic [MASK_BITS-1:0] day_mask;
        logic [SEC_BITS-1:0]  fire_seconds;
        logic [RCNT_BITS-1:0] repeat_count;
        logic [RMIN_BITS-1:0] repeat_minutes;
    } t_cfg;

    // Classified query handed from front to back
    typedef struct packed {
        logic                 never;
        logic                 today_ok;
        logic                 rep_try;
        logic [WDAY_BITS-1:0] ahead;
        logic [OUT_BITS-1:0]  base;
        logic [SEC_BITS-1:0]  elapsed;
    } t_job;

endpackage

FILE: hdl/weekly_schedule_next_time.sv
// Top level of the weekly schedule next-time block: configuration registers
// and the front end, queue and back end. Depends on wsnt_pkg.
//
// Use: each query (now_epoch, weekday, day_seconds) enters on the input
// channel (i_valid / o_stall / i_item) and yields exactly one result
// (next_epoch, never) on the output channel (o_valid / i_stall / o_result),
// in query order. A transfer happens at a clock edge with valid high and
// stall low.
// Path: a query passes the front-end register loaded at its transfer, one
// queue slot, then twelve back-end stages of which eight are the
// one-bit-per-stage repeat divider.
// Throughput: one query per cycle while the output is not stalled.
// A stall on the output freezes the whole back end and holds the result; the
// four-entry queue keeps taking queries until it fills, then o_stall rises.
// Reset (synchronous, active low) empties the pipeline and queue and loads
// the register defaults: enabled, all days, fire at midnight, no repeats,
// 60-minute repeat step. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) take effect at once and belong only to idle periods.
module weekly_schedule_next_time import wsnt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_item                o_result
);

    t_cfg r_cfg;
    logic fr_valid;
    t_job fr_job;
    logic q_full;
    logic q_empty;
    t_job q_job;
    logic bk_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled        <= 1'b1;
            r_cfg.day_mask       <= '1;
            r_cfg.fire_seconds   <= '0;
            r_cfg.repeat_count   <= '0;
            r_cfg.repeat_minutes <= RMIN_BITS'(60);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:     r_cfg.enabled        <= i_cfg_data[0];
                REG_DAY_MASK:   r_cfg.day_mask       <= i_cfg_data[MASK_BITS-1:0];
                REG_FIRE_SECS:  r_cfg.fire_seconds   <= i_cfg_data[SEC_BITS-1:0];
                REG_REPEAT_CNT: r_cfg.repeat_count   <= i_cfg_data[RCNT_BITS-1:0];
                REG_REPEAT_MIN: r_cfg.repeat_minutes <= i_cfg_data[RMIN_BITS-1:0];
                default:        r_cfg                <= r_cfg;
            endcase
        end
    end

    wsnt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (fr_valid),
        .o_job   (fr_job),
        .i_full  (q_full)
    );

    wsnt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_job),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    wsnt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_job    (q_job),
        .o_pop    (bk_pop),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

FILE: hdl/wsnt_front.sv
// Front end: takes queries, classifies them and forms the base time.
// Depends on wsnt_pkg.
module wsnt_front import wsnt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    output logic     o_valid,
    output t_job     o_job,
    input  logic     i_full
);

    // (w + d) mod 7 for w, d below 7
    function automatic logic [WDAY_BITS-1:0] wrap_day(logic [WDAY_BITS-1:0] w,
                                                      logic [WDAY_BITS-1:0] d);
        logic [WDAY_BITS:0] s;
        s = {1'b0, w} + {1'b0, d};
        if (s >= (WDAY_BITS+1)'(WEEK_DAYS)) begin
            s = s - (WDAY_BITS+1)'(WEEK_DAYS);
        end
        return s[WDAY_BITS-1:0];
    endfunction

    logic                 r_valid;
    t_job                 r_job;
    t_job                 n_job;
    logic [MASK_BITS:0]   mask8;
    logic [WDAY_BITS-1:0] wday_base;
    logic                 marked;

    assign o_stall = r_valid && i_full;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    // weekday seven has no day bit and searches from Sunday
    assign mask8     = {1'b0, i_cfg.day_mask};
    assign marked    = mask8[i_item.weekday];
    assign wday_base = (i_item.weekday > WDAY_BITS'(WEEK_DAYS - 1)) ? '0 : i_item.weekday;

    // Classification
    always_comb begin
        n_job.never    = !i_cfg.enabled || (i_cfg.day_mask == '0);
        n_job.base     = {1'b0, i_item.now_epoch} + OUT_BITS'(i_cfg.fire_seconds)
                         - OUT_BITS'(i_item.day_seconds);
        n_job.today_ok = marked && (i_cfg.fire_seconds >= i_item.day_seconds);
        n_job.rep_try  = marked && (i_cfg.fire_seconds < i_item.day_seconds)
                         && (i_cfg.repeat_minutes != '0);
        n_job.elapsed  = i_item.day_seconds - i_cfg.fire_seconds;
        // nearest marked day ahead; a full week if none
        n_job.ahead    = WDAY_BITS'(WEEK_DAYS);
        for (int d = WEEK_DAYS - 1; d >= 1; d--) begin
            if (mask8[wrap_day(wday_base, WDAY_BITS'(d))]) begin
                n_job.ahead = WDAY_BITS'(d);
            end
        end
    end

    // Output stage, held while it holds a query and the queue is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: hdl/wsnt_queue.sv
// Short queue decoupling the front end from the back end.
// Depends on wsnt_pkg.
module wsnt_queue import wsnt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/wsnt_back.sv
// Back end: repeat check, pipelined divider, repeat product and result select.
// Depends on wsnt_pkg.
module wsnt_back import wsnt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_stall
);

    typedef struct packed {
        logic                never;
        logic                today_ok;
        logic                rep_ok;
        logic [OUT_BITS-1:0] base;
        logic [OUT_BITS-1:0] day_epoch;
        logic [SEC_BITS-1:0] rem;
        logic [QUO_BITS-1:0] quo;
    } t_div;

    logic                   en;
    logic [STEP_BITS-1:0]   step;
    logic [LIMIT_BITS-1:0]  limit;

    logic                   r_a_valid;
    t_job                   r_a_job;
    logic [LIMIT_BITS-1:0]  r_a_limit;
    logic [DOFS_BITS-1:0]   r_a_dofs;

    logic                   r_b_valid;
    t_div                   r_b;
    t_div                   n_b;

    logic [QUO_BITS-1:0]    r_d_valid;
    t_div                   r_d [QUO_BITS];
    t_div                   n_d [QUO_BITS];

    logic                   r_m_valid;
    t_div                   r_m;
    logic [PROD_BITS-1:0]   r_m_prod;
    logic [QUO_BITS:0]      k;

    logic                   r_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    // Whole pipeline advances unless the result is held
    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !i_empty;

    assign step  = STEP_BITS'(i_cfg.repeat_minutes) * STEP_BITS'(MIN_SECS);
    assign limit = LIMIT_BITS'(i_cfg.repeat_count) * LIMIT_BITS'(step);

    // Stage B: repeat range check and next-day time
    always_comb begin
        n_b.never     = r_a_job.never;
        n_b.today_ok  = r_a_job.today_ok;
        n_b.rep_ok    = r_a_job.rep_try && (LIMIT_BITS'(r_a_job.elapsed) < r_a_limit);
        n_b.base      = r_a_job.base;
        n_b.day_epoch = r_a_job.base + OUT_BITS'(r_a_dofs);
        n_b.rem       = r_a_job.elapsed;
        n_b.quo       = '0;
    end

    // Divider: one quotient bit per stage, most significant first
    always_comb begin
        t_div                  cur;
        logic [LIMIT_BITS-1:0] trial;
        for (int i = 0; i < QUO_BITS; i++) begin
            cur   = (i == 0) ? r_b : r_d[(i == 0) ? 0 : i - 1];
            trial = LIMIT_BITS'(step) << (QUO_BITS - 1 - i);
            if (LIMIT_BITS'(cur.rem) >= trial) begin
                cur.rem = SEC_BITS'(LIMIT_BITS'(cur.rem) - trial);
                cur.quo[QUO_BITS-1-i] = 1'b1;
            end
            n_d[i] = cur;
        end
    end

    assign k = {1'b0, r_d[QUO_BITS-1].quo} + 1'b1;

    // Result select
    always_comb begin
        n_out.never = r_m.never;
        if (r_m.never) begin
            n_out.next_epoch = '0;
        end else if (r_m.today_ok) begin
            n_out.next_epoch = r_m.base;
        end else if (r_m.rep_ok) begin
            n_out.next_epoch = r_m.base + OUT_BITS'(r_m_prod);
        end else begin
            n_out.next_epoch = r_m.day_epoch;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_d_valid   <= '0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= !i_empty;
            r_b_valid   <= r_a_valid;
            r_d_valid   <= {r_d_valid[QUO_BITS-2:0], r_b_valid};
            r_m_valid   <= r_d_valid[QUO_BITS-1];
            r_out_valid <= r_m_valid;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_job   <= i_job;
            r_a_limit <= limit;
            r_a_dofs  <= DOFS_BITS'(i_job.ahead) * DOFS_BITS'(DAY_SECS);
            r_b       <= n_b;
            for (int i = 0; i < QUO_BITS; i++) begin
                r_d[i] <= n_d[i];
            end
            r_m       <= r_d[QUO_BITS-1];
            r_m_prod  <= PROD_BITS'(k) * PROD_BITS'(step);
            r_out     <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: hdl/wsnt_checker.sv
// Port-level checks for the weekly schedule next-time block, bound to the top.
// Depends on wsnt_pkg.
module wsnt_checker import wsnt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_stall,
    input logic      o_valid,
    input logic      o_stall,
    input t_out_item o_result
);

    // Nothing is offered in the cycle after reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // Front end is empty after reset, so no back-pressure
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled straight after reset");

    // A never result carries a zero time
    a_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.never |-> o_result.next_epoch == '0)
        else $error("never result with non-zero time");

    // A held result stays offered and unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

endmodule

bind weekly_schedule_next_time wsnt_checker u_wsnt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_stall  (i_stall),
    .o_valid  (o_valid),
    .o_stall  (o_stall),
    .o_result (o_result)
);
